// ===== hw/rtl/mclp_pkg.sv =====
// ----------------------------------------------------------------------------
// Motion command line parser package
// Character codes, direction codes and the letter decoder shared by the parser.
// ----------------------------------------------------------------------------
package mclp_pkg;

  localparam int unsigned LineLengthDefault = 8;

  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChF    = 8'h46;
  localparam logic [7:0] ChB    = 8'h42;
  localparam logic [7:0] ChL    = 8'h4C;
  localparam logic [7:0] ChR    = 8'h52;
  localparam logic [7:0] ChS    = 8'h53;

  localparam logic [11:0] SpeedMax    = 12'd255;
  localparam logic [11:0] DecimalBase = 12'd10;

  typedef enum logic [2:0] {
    DirStop     = 3'd0,
    DirForward  = 3'd1,
    DirBackward = 3'd2,
    DirLeft     = 3'd3,
    DirRight    = 3'd4
  } direction_e;

  typedef struct packed {
    logic       known;
    direction_e dir;
  } dir_decode_t;

  function automatic dir_decode_t decode_letter(logic [7:0] letter);
    dir_decode_t res;
    res.known = 1'b1;
    res.dir   = DirStop;
    unique case (letter)
      ChS:     res.dir = DirStop;
      ChF:     res.dir = DirForward;
      ChB:     res.dir = DirBackward;
      ChL:     res.dir = DirLeft;
      ChR:     res.dir = DirRight;
      default: res.known = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/motion_command_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Motion command line parser
// Collects received characters into a line and turns each complete command
// line into a direction and a decimal speed.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                      | Payload
//  --------+--------------------------------+-------------------------
//  in      | in_valid_i / in_ready_o        | rx_byte_i[7:0]
//  out     | out_valid_o / out_ready_i      | direction_o[2:0], speed_o[7:0]
//
// One word is taken in every cycle the input is not stalled; the line state is
// updated as the word is accepted, and a line end loads the output register with it.
// The line state and the output register are the only storage; the digit step
// (multiply by ten, add, saturate) feeds the running speed in the line state.
// The input stalls only while a result waits in the output register and the
// sink is not ready to take it.
// Reset clears the line count, the letter, the running speed and the output valid.
//
module motion_command_line_parser_unit
  import mclp_pkg::*;
#(
  parameter int unsigned LineLength = LineLengthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] direction_o,
  output logic [7:0] speed_o
);

  localparam int unsigned CountW = $clog2(LineLength + 1);

  logic [CountW-1:0] line_count_q, line_count_d;
  logic [7:0]        first_letter_q, first_letter_d;
  logic [7:0]        running_speed_q, running_speed_d;
  logic              in_digits_q, in_digits_d;

  logic              out_valid_q, out_valid_d;
  direction_e        direction_q, direction_d;
  logic [7:0]        speed_q, speed_d;

  logic              in_accept;
  logic              is_term;
  logic              is_digit;
  logic [11:0]       speed_ext;
  dir_decode_t       dec;
  logic              emit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign is_term    = (rx_byte_i == ChCr) || (rx_byte_i == ChLf);
  assign is_digit   = (rx_byte_i >= ChZero) && (rx_byte_i <= ChNine);
  assign dec        = decode_letter(first_letter_q);
  assign speed_ext  = 12'(running_speed_q) * DecimalBase + 12'(rx_byte_i[3:0]);

  always_comb begin
    line_count_d    = line_count_q;
    first_letter_d  = first_letter_q;
    running_speed_d = running_speed_q;
    in_digits_d     = in_digits_q;
    emit            = 1'b0;
    if (in_accept) begin
      if (is_term) begin
        // An empty line is ignored; otherwise the line ends here.
        if (line_count_q != '0) begin
          line_count_d = '0;
          emit         = dec.known;
        end
      end else if (line_count_q >= CountW'(LineLength)) begin
        // Overlong line: the word is dropped and the line starts afresh.
        line_count_d = '0;
      end else begin
        if (line_count_q == '0) begin
          first_letter_d  = rx_byte_i;
          running_speed_d = '0;
          in_digits_d     = 1'b1;
        end else if (in_digits_q) begin
          if (is_digit) begin
            running_speed_d = (speed_ext > SpeedMax) ? 8'hFF : speed_ext[7:0];
          end else begin
            in_digits_d = 1'b0;
          end
        end
        line_count_d = line_count_q + CountW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    direction_d = direction_q;
    speed_d     = speed_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      direction_d = dec.dir;
      speed_d     = (dec.dir == DirStop) ? 8'd0 : running_speed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q    <= '0;
      first_letter_q  <= '0;
      running_speed_q <= '0;
      in_digits_q     <= 1'b1;
      out_valid_q     <= 1'b0;
    end else begin
      line_count_q    <= line_count_d;
      first_letter_q  <= first_letter_d;
      running_speed_q <= running_speed_d;
      in_digits_q     <= in_digits_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    direction_q <= direction_d;
    speed_q     <= speed_d;
  end

  assign out_valid_o = out_valid_q;
  assign direction_o = direction_q;
  assign speed_o     = speed_q;

  // The line never holds more characters than its length allows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_count_q <= CountW'(LineLength))
    else $error("line count beyond line length");

  // A stop command always carries zero speed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (direction_o == DirStop) |-> speed_o == 8'd0)
    else $error("stop result with non-zero speed");

  // A terminator on an empty line leaves no fresh result behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && is_term && (line_count_q == '0) && out_ready_i |=> !out_valid_o)
    else $error("result produced for an empty line");

  // Every line end with a known letter delivers a result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && is_term && (line_count_q != '0) && dec.known |=> out_valid_o)
    else $error("command line end lost");

endmodule

// ===== bench/mclp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motion command checker
// Watches both channels of the line parser, works out the command that each
// received line should produce and compares every result word with it.
// ----------------------------------------------------------------------------
module mclp_checker
  import mclp_pkg::*;
#(
  parameter int unsigned LineLength = LineLengthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  direction_i,
  input  logic [7:0]  speed_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    direction_e dir;
    logic [7:0] speed;
  } motion_cmd_t;

  motion_cmd_t cmd_q[$];
  int unsigned fails = 0;

  // Shadow copy of the line being collected.
  logic [3:0] line_len    = '0;
  logic [7:0] lead_char   = '0;
  logic [7:0] speed_acc   = '0;
  logic       in_digits   = 1'b1;

  assign fail_count_o = fails;
  assign pending_o    = cmd_q.size();

  task automatic parse_word(input logic [7:0] b);
    motion_cmd_t cmd;
    logic        known;
    int unsigned acc;
    known = 1'b1;
    cmd.speed = speed_acc;
    if (b == ChCr || b == ChLf) begin
      if (line_len != 0) begin
        line_len = '0;
        case (lead_char)
          ChS: begin
            cmd.dir   = DirStop;
            cmd.speed = '0;
          end
          ChF: cmd.dir = DirForward;
          ChB: cmd.dir = DirBackward;
          ChL: cmd.dir = DirLeft;
          ChR: cmd.dir = DirRight;
          default: begin
            cmd.dir = DirStop;
            known   = 1'b0;
          end
        endcase
        if (known) cmd_q.push_back(cmd);
      end
    end else if (line_len >= LineLength) begin
      // An overlong line is thrown away together with this word.
      line_len = '0;
    end else begin
      if (line_len == 0) begin
        lead_char = b;
        speed_acc = '0;
        in_digits = 1'b1;
      end else if (in_digits) begin
        if (b >= ChZero && b <= ChNine) begin
          acc = speed_acc * DecimalBase + (b - ChZero);
          speed_acc = (acc > SpeedMax) ? SpeedMax[7:0] : acc[7:0];
        end else begin
          in_digits = 1'b0;
        end
      end
      line_len = line_len + 4'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    motion_cmd_t want;
    if (!rst_ni) begin
      line_len  = '0;
      lead_char = '0;
      speed_acc = '0;
      in_digits = 1'b1;
      cmd_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) parse_word(rx_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (cmd_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual dir %0d speed %0d",
                   $time, direction_i, speed_i);
        end else begin
          want = cmd_q.pop_front();
          if (direction_i !== want.dir) begin
            fails++;
            $display("%0t: direction mismatch, expected %0d, actual %0d",
                     $time, want.dir, direction_i);
          end
          if (speed_i !== want.speed) begin
            fails++;
            $display("%0t: speed mismatch, expected %0d, actual %0d",
                     $time, want.speed, speed_i);
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motion command line parser testbench
// Sends directed and random command lines with random gaps and stalls on
// both channels; the checker predicts and compares, this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
  import mclp_pkg::*;

  localparam int unsigned WordTarget = 700;
  localparam int unsigned CycleLimit = 200000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] direction_o;
  logic [7:0] speed_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned send_calm = 0;

  motion_command_line_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .direction_o (direction_o),
    .speed_o     (speed_o)
  );

  mclp_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .direction_i  (direction_o),
    .speed_i      (speed_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Valid is only lowered when a gap follows, so it never drops between
  // back-to-back words.
  task automatic send_word(input logic [7:0] b);
    int unsigned gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  function automatic logic [7:0] line_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == ChCr || c == ChLf) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] digit_char();
    return ChZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] end_char();
    return $urandom_range(0, 1) ? ChCr : ChLf;
  endfunction

  // Mostly well-formed command lines with random content; the rest are
  // unknown letters, overlong lines, empty lines and raw noise.
  task automatic send_random_line();
    logic [7:0]  letters [5];
    logic [7:0]  lead;
    int unsigned pick;
    int unsigned n_dig;
    int unsigned n_tail;
    letters = '{ChS, ChF, ChB, ChL, ChR};
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      lead = ($urandom_range(0, 19) < 18) ? letters[3'($urandom_range(0, 4))] : line_char();
      n_dig = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
      n_tail = (n_dig < 7 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7 - n_dig) : 0;
      send_word(lead);
      repeat (n_dig) send_word(digit_char());
      repeat (n_tail) send_word($urandom_range(0, 1) ? digit_char() : line_char());
      send_word(end_char());
    end else if (pick < 85) begin
      send_word(letters[3'($urandom_range(0, 4))]);
      repeat ($urandom_range(8, 11)) send_word($urandom_range(0, 1) ? digit_char() : line_char());
      send_word(end_char());
    end else if (pick < 90) begin
      send_word(end_char());
    end else begin
      repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    logic paused;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("F255");
    send_word(ChCr);
    send_text("B999");
    send_word(ChLf);
    send_text("S7");
    send_word(ChCr);
    send_word(ChCr);
    send_text("Q");
    send_word(ChLf);
    send_text("L");
    send_word(8'hFF);
    send_word(8'h00);
    send_word(ChCr);
    // Nine characters: the last one overflows the line and is dropped, and the line starts afresh.
    send_text("R12345678");
    send_word(ChLf);

    while (words_sent < WordTarget) begin
      send_random_line();
      if (!paused && words_sent > WordTarget / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        paused = 1'b1;
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : sink
    int unsigned stall;
    int unsigned calm;
    int unsigned taken;
    calm  = 0;
    taken = 0;
    wait (rst_ni);
    forever begin
      // Two long hold-offs let the output register fill and stall the input.
      if (taken == 15 || taken == 90) begin
        stall = 300;
      end else if (calm > 0) begin
        calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 9);
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(5, 20);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

endmodule
